### rtl/slma_pkg.sv
// Shared types, sizes and saturating Q16.16 helpers for the sparse lower-matrix
// assembly store. No dependencies; used by the core and by its checker.
package slma_pkg;

	localparam int MAX_ORDER   = 1024;
	localparam int MAX_ENTRIES = 8192;
	localparam int ROW_W       = 11;
	localparam int COL_W       = 10;
	localparam int POS_W       = 14;
	localparam int ENT_AW      = 13;
	localparam int VAL_W       = 32;

	localparam logic [POS_W-1:0]   ENTRIES_LIM = POS_W'(MAX_ENTRIES);
	localparam logic [ROW_W-1:0]   ORDER_LIM   = ROW_W'(MAX_ORDER);
	localparam logic signed [31:0] Q_ONE       = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX       = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN       = 32'sh8000_0000;

	typedef enum logic [2:0] {
		OP_SET_START = 3'd0,
		OP_SET_COL   = 3'd1,
		OP_ADD_LOWER = 3'd2,
		OP_ADD_DIAG  = 3'd3,
		OP_ADD_RHS   = 3'd4,
		OP_BOUNDARY  = 3'd5,
		OP_READ      = 3'd6,
		OP_CLEAR     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DISP, S_UPD, S_BND_LO, S_BND_HI, S_WALK_RD, S_WALK_CHK,
		S_MUL, S_RND, S_SUB, S_NEXT, S_VAL_RD, S_VAL_CAP, S_RESP
	} state_t;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
		return s[31:0];
	endfunction

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} - {b[31], b};
		if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
		return s[31:0];
	endfunction

	// Round a Q32.32 product to Q16.16, ties toward +inf, then saturate
	function automatic logic signed [31:0] q_round(input logic signed [63:0] p);
		logic signed [63:0] t;
		logic signed [47:0] sh;
		t  = p + 64'sd32768;
		sh = t[63:16];
		if (sh[47:31] != {17{sh[31]}}) return sh[47] ? Q_MIN : Q_MAX;
		return sh[31:0];
	endfunction

	function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
		return (p > ENTRIES_LIM) ? ENTRIES_LIM : p;
	endfunction

endpackage

### rtl/sparse_lower_matrix_assembly_core.sv
// Add lower searches the row's entries in turn; boundary walks its own row's entries
// and then every later row, zeroing each coupled entry and subtracting it times the
// value from the right-hand side. Throughput: one item at a time, s_tready in idle only.
// Reset: arst_n clears control, then a sweep zeroes the value memories (no item
// accepted meanwhile); op clear repeats the same sweep.
// Depends on slma_pkg.
module sparse_lower_matrix_assembly_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [10:0]  cfg_wdata,   // matrix_order
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,     // row[10:0], col[20:11], pos[34:21], value[66:35]
	input  logic [2:0]   s_tuser,     // op[2:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,     // diag_out[31:0], rhs_out[63:32], entry_out[95:64]
	output logic [1:0]   m_tuser      // status[1:0]
);

	slma_pkg::state_t st_q, st_d;

	logic [10:0]        order_q;
	slma_pkg::op_t      op_q;
	logic [10:0]        row_q, jrow_q, nj;
	logic [9:0]         col_q, tgt_q;
	logic [13:0]        pos_q, lo_q, hi_q, k_q;
	logic signed [31:0] val_q, lv_q, rh_q, qm_q, d_q, r_q, e_q;
	logic signed [63:0] prod_q;
	logic [12:0]        clr_q;
	logic               clr_op_q, phase_q;
	slma_pkg::status_t  status_q;
	logic               m_tvalid_q;
	logic [95:0]        m_tdata_q;
	logic [1:0]         m_tuser_q;

	logic row_ok, pos_ok, walk_hit, out_free, accept;
	logic [10:0] order_eff;

	// memory ports
	logic               rs_we, ci_we, lv_we, dg_we, rh_we;
	logic [10:0]        rs_waddr, rs_raddr;
	logic [13:0]        rs_wdata, rs_rd;
	logic [12:0]        ci_waddr, ci_raddr, lv_waddr, lv_raddr;
	logic [9:0]         ci_rd, dg_waddr, dg_raddr, rh_waddr, rh_raddr;
	logic signed [31:0] lv_wdata, lv_rd, dg_wdata, dg_rd, rh_wdata, rh_rd;

	logic [13:0]        rs_mem [0:1024];
	logic [9:0]         ci_mem [0:8191];
	logic signed [31:0] lv_mem [0:8191];
	logic signed [31:0] dg_mem [0:1023];
	logic signed [31:0] rh_mem [0:1023];

	assign s_tready  = (st_q == slma_pkg::S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign out_free  = !m_tvalid_q || m_tready;
	assign row_ok    = !row_q[10];
	assign pos_ok    = !pos_q[13];
	assign order_eff = (order_q > slma_pkg::ORDER_LIM) ? slma_pkg::ORDER_LIM : order_q;
	assign nj        = phase_q ? (jrow_q + 11'd1) : (row_q + 11'd1);

	// Match test on the fetched column
	always_comb begin
		if (op_q == slma_pkg::OP_ADD_LOWER) walk_hit = (ci_rd == col_q);
		else if (!phase_q)                  walk_hit = 1'b1;
		else                                walk_hit = (ci_rd == row_q[9:0]);
	end

	// Next state and memory controls
	always_comb begin
		st_d     = st_q;
		rs_we    = 1'b0; rs_waddr = row_q; rs_wdata = pos_q; rs_raddr = row_q;
		ci_we    = 1'b0; ci_waddr = pos_q[12:0]; ci_raddr = k_q[12:0];
		lv_we    = 1'b0; lv_waddr = k_q[12:0]; lv_wdata = '0; lv_raddr = k_q[12:0];
		dg_we    = 1'b0; dg_waddr = row_q[9:0]; dg_wdata = '0; dg_raddr = row_q[9:0];
		rh_we    = 1'b0; rh_waddr = row_q[9:0]; rh_wdata = '0; rh_raddr = row_q[9:0];
		case (st_q)
			slma_pkg::S_CLEAR: begin
				lv_we = 1'b1; lv_waddr = clr_q;
				dg_we = 1'b1; dg_waddr = clr_q[9:0];
				rh_we = 1'b1; rh_waddr = clr_q[9:0];
				if (clr_q == 13'(slma_pkg::MAX_ENTRIES - 1))
					st_d = clr_op_q ? slma_pkg::S_RESP : slma_pkg::S_IDLE;
			end
			slma_pkg::S_IDLE: begin
				if (accept) st_d = slma_pkg::S_DISP;
			end
			slma_pkg::S_DISP: begin
				lv_raddr = pos_q[12:0];
				case (op_q)
					slma_pkg::OP_SET_START: begin
						rs_we = (row_q <= slma_pkg::ORDER_LIM);
						st_d  = slma_pkg::S_RESP;
					end
					slma_pkg::OP_SET_COL: begin
						ci_we = pos_ok;
						st_d  = pos_ok ? slma_pkg::S_VAL_CAP : slma_pkg::S_RESP;
					end
					slma_pkg::OP_ADD_LOWER: begin
						st_d = row_ok ? slma_pkg::S_BND_LO : slma_pkg::S_RESP;
					end
					slma_pkg::OP_ADD_DIAG, slma_pkg::OP_ADD_RHS: begin
						st_d = row_ok ? slma_pkg::S_UPD : slma_pkg::S_RESP;
					end
					slma_pkg::OP_BOUNDARY: begin
						if (row_ok) begin
							dg_we = 1'b1; dg_wdata = slma_pkg::Q_ONE;
							rh_we = 1'b1; rh_wdata = val_q;
							st_d  = slma_pkg::S_BND_LO;
						end else begin
							st_d = slma_pkg::S_RESP;
						end
					end
					slma_pkg::OP_READ: st_d = slma_pkg::S_VAL_CAP;
					default:           st_d = slma_pkg::S_CLEAR;
				endcase
			end
			slma_pkg::S_UPD: begin
				if (op_q == slma_pkg::OP_ADD_DIAG) begin
					dg_we = 1'b1; dg_wdata = slma_pkg::sat_add(dg_rd, val_q);
				end else begin
					rh_we = 1'b1; rh_wdata = slma_pkg::sat_add(rh_rd, val_q);
				end
				st_d = slma_pkg::S_VAL_RD;
			end
			slma_pkg::S_BND_LO: begin
				rs_raddr = jrow_q + 11'd1;
				st_d     = slma_pkg::S_BND_HI;
			end
			slma_pkg::S_BND_HI: st_d = slma_pkg::S_WALK_RD;
			slma_pkg::S_WALK_RD: begin
				st_d = (k_q < hi_q) ? slma_pkg::S_WALK_CHK : slma_pkg::S_NEXT;
			end
			slma_pkg::S_WALK_CHK: begin
				if (!walk_hit) begin
					st_d = slma_pkg::S_WALK_RD;
				end else if (op_q == slma_pkg::OP_ADD_LOWER) begin
					lv_we    = 1'b1;
					lv_wdata = slma_pkg::sat_add(lv_rd, val_q);
					st_d     = slma_pkg::S_VAL_RD;
				end else begin
					// zero the entry now; its value is held for the coupling
					lv_we    = 1'b1;
					rh_raddr = phase_q ? jrow_q[9:0] : ci_rd;
					st_d     = slma_pkg::S_MUL;
				end
			end
			slma_pkg::S_MUL: st_d = slma_pkg::S_RND;
			slma_pkg::S_RND: st_d = slma_pkg::S_SUB;
			slma_pkg::S_SUB: begin
				rh_we    = 1'b1;
				rh_waddr = tgt_q;
				rh_wdata = slma_pkg::sat_sub(rh_q, qm_q);
				st_d     = slma_pkg::S_WALK_RD;
			end
			slma_pkg::S_NEXT: begin
				rs_raddr = nj;
				if (op_q == slma_pkg::OP_BOUNDARY && nj < order_eff)
					st_d = slma_pkg::S_BND_LO;
				else
					st_d = slma_pkg::S_VAL_RD;
			end
			slma_pkg::S_VAL_RD: begin
				lv_raddr = pos_q[12:0];
				st_d     = slma_pkg::S_VAL_CAP;
			end
			slma_pkg::S_VAL_CAP: st_d = slma_pkg::S_RESP;
			slma_pkg::S_RESP: begin
				if (out_free) st_d = slma_pkg::S_IDLE;
			end
			default: st_d = slma_pkg::S_IDLE;
		endcase
	end

	// State and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= slma_pkg::S_CLEAR;
			order_q  <= 11'd1024;
			clr_q    <= '0;
			clr_op_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_wen) order_q <= cfg_wdata;
			if (st_q == slma_pkg::S_CLEAR) begin
				clr_q <= clr_q + 13'd1;
				if (st_d != slma_pkg::S_CLEAR) clr_op_q <= 1'b0;
			end
			if (st_q == slma_pkg::S_DISP && op_q == slma_pkg::OP_CLEAR) begin
				clr_q    <= '0;
				clr_op_q <= 1'b1;
			end
		end
	end

	// Item working registers
	always_ff @(posedge clk) begin
		case (st_q)
			slma_pkg::S_IDLE: begin
				if (accept) begin
					op_q     <= slma_pkg::op_t'(s_tuser);
					row_q    <= s_tdata[10:0];
					jrow_q   <= s_tdata[10:0];
					col_q    <= s_tdata[20:11];
					pos_q    <= s_tdata[34:21];
					val_q    <= s_tdata[66:35];
					status_q <= slma_pkg::ST_OK;
					phase_q  <= 1'b0;
					d_q      <= '0;
					r_q      <= '0;
					e_q      <= '0;
				end
			end
			slma_pkg::S_DISP: begin
				case (op_q)
					slma_pkg::OP_SET_START:
						if (row_q > slma_pkg::ORDER_LIM) status_q <= slma_pkg::ST_RANGE;
					slma_pkg::OP_SET_COL:
						if (!pos_ok) status_q <= slma_pkg::ST_RANGE;
					slma_pkg::OP_READ:
						if (!pos_ok || !row_ok) status_q <= slma_pkg::ST_RANGE;
					slma_pkg::OP_CLEAR: ;
					default:
						if (!row_ok) status_q <= slma_pkg::ST_RANGE;
				endcase
			end
			slma_pkg::S_BND_LO: lo_q <= slma_pkg::clamp_pos(rs_rd);
			slma_pkg::S_BND_HI: begin
				hi_q <= slma_pkg::clamp_pos(rs_rd);
				k_q  <= lo_q;
			end
			slma_pkg::S_WALK_CHK: begin
				lv_q  <= lv_rd;
				tgt_q <= phase_q ? jrow_q[9:0] : ci_rd;
				if (!walk_hit) k_q <= k_q + 14'd1;
				else if (op_q == slma_pkg::OP_ADD_LOWER) e_q <= slma_pkg::sat_add(lv_rd, val_q);
			end
			slma_pkg::S_MUL: begin
				prod_q <= lv_q * val_q;
				rh_q   <= rh_rd;
			end
			slma_pkg::S_RND: qm_q <= slma_pkg::q_round(prod_q);
			slma_pkg::S_SUB: k_q <= k_q + 14'd1;
			slma_pkg::S_NEXT: begin
				if (op_q == slma_pkg::OP_ADD_LOWER) status_q <= slma_pkg::ST_NOT_FOUND;
				jrow_q  <= nj;
				phase_q <= 1'b1;
			end
			slma_pkg::S_VAL_CAP: begin
				if (op_q inside {[slma_pkg::OP_ADD_LOWER:slma_pkg::OP_READ]} && row_ok) begin
					d_q <= dg_rd;
					r_q <= rh_rd;
				end
				if ((op_q == slma_pkg::OP_SET_COL || op_q == slma_pkg::OP_READ) && pos_ok)
					e_q <= lv_rd;
			end
			default: ;
		endcase
	end

	// Output register: load the finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (st_q == slma_pkg::S_RESP && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == slma_pkg::S_RESP && out_free) begin
			m_tdata_q <= {e_q, r_q, d_q};
			m_tuser_q <= status_q;
		end
	end

	// Memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (rs_we) rs_mem[rs_waddr] <= rs_wdata;
		rs_rd <= rs_mem[rs_raddr];
	end

	always_ff @(posedge clk) begin
		if (ci_we) ci_mem[ci_waddr] <= col_q;
		ci_rd <= ci_mem[ci_raddr];
	end

	always_ff @(posedge clk) begin
		if (lv_we) lv_mem[lv_waddr] <= lv_wdata;
		lv_rd <= lv_mem[lv_raddr];
	end

	always_ff @(posedge clk) begin
		if (dg_we) dg_mem[dg_waddr] <= dg_wdata;
		dg_rd <= dg_mem[dg_raddr];
	end

	always_ff @(posedge clk) begin
		if (rh_we) rh_mem[rh_waddr] <= rh_wdata;
		rh_rd <= rh_mem[rh_raddr];
	end

endmodule

### rtl/slma_checker.sv
// Port-level checks for the sparse lower-matrix assembly core, bound to the top.
// Depends on slma_pkg and sparse_lower_matrix_assembly_core.
module slma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wen,
	input logic [10:0] cfg_wdata,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [71:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// one item at a time: busy right after a beat is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// status code stays within its defined set
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == slma_pkg::ST_OK || m_tuser == slma_pkg::ST_NOT_FOUND ||
			m_tuser == slma_pkg::ST_RANGE))
		else $error("bad status");

	// a missed column returns no entry value
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == slma_pkg::ST_NOT_FOUND |-> m_tdata[95:64] == 32'd0)
		else $error("entry value on not found");

endmodule

bind sparse_lower_matrix_assembly_core slma_checker u_slma_checker (.*);
